### rtl/core/qast_pkg.sv
// Shared types and constants for the quad affine step transform core.
// Used by the register block, the lanes and the top level.
`timescale 1ns / 1ps

package qast_pkg;

	localparam int STEP_W      = 16;
	localparam int FACTOR_W    = 18;
	localparam int FACTOR_FRAC = 16;
	// coefficient width once the sine may be negated (-(-2^17) needs one more bit)
	localparam int KW          = FACTOR_W + 1;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_ADDR_W  = 5;

	typedef enum logic [1:0] {
		ACT_PLACE  = 2'd0,
		ACT_MOVE   = 2'd1,
		ACT_SCALE  = 2'd2,
		ACT_ROTATE = 2'd3
	} act_t;

	typedef logic [2:0] dir_t;

	// move directions; anything else leaves the quad in place
	localparam dir_t DIR_UP    = 3'd0;
	localparam dir_t DIR_DOWN  = 3'd1;
	localparam dir_t DIR_LEFT  = 3'd2;
	localparam dir_t DIR_RIGHT = 3'd3;
	// scale: enlarge code, all others shrink; rotate: ccw code, all others cw
	localparam dir_t DIR_ENLARGE = 3'd0;
	localparam dir_t DIR_CCW     = 3'd0;

	typedef enum logic [2:0] {
		REG_MOVE_STEP  = 3'd0,
		REG_SCALE_UP   = 3'd1,
		REG_SCALE_DOWN = 3'd2,
		REG_ROT_COS    = 3'd3,
		REG_ROT_SIN    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [STEP_W-1:0]          move_step;
		logic [FACTOR_W-1:0]        scale_up;
		logic [FACTOR_W-1:0]        scale_down;
		logic signed [FACTOR_W-1:0] rot_cos;
		logic signed [FACTOR_W-1:0] rot_sin;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		move_step:  16'd3277,
		scale_up:   18'd75366,
		scale_down: 18'd56988,
		rot_cos:    18'sd65209,
		rot_sin:    18'sd6543
	};

endpackage

### rtl/core/qast_if.sv
// Request and result channel interfaces (valid/ready) of the transform core.
// Depends on nothing; coordinate width follows COORD_WIDTH.
`timescale 1ns / 1ps

interface qast_cmd_if #(parameter int COORD_WIDTH = 24) ();
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [2:0]                    direction;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic [COORD_WIDTH-2:0]        box_width;
	logic [COORD_WIDTH-2:0]        box_height;

	modport source (output valid, action, direction, center_x, center_y, box_width, box_height,
		input ready);
	modport sink (input valid, action, direction, center_x, center_y, box_width, box_height,
		output ready);
endinterface

interface qast_res_if #(parameter int COORD_WIDTH = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] top_left_x;
	logic signed [COORD_WIDTH-1:0] top_left_y;
	logic signed [COORD_WIDTH-1:0] top_right_x;
	logic signed [COORD_WIDTH-1:0] top_right_y;
	logic signed [COORD_WIDTH-1:0] bottom_right_x;
	logic signed [COORD_WIDTH-1:0] bottom_right_y;
	logic signed [COORD_WIDTH-1:0] bottom_left_x;
	logic signed [COORD_WIDTH-1:0] bottom_left_y;
	logic signed [COORD_WIDTH-1:0] centroid_x;
	logic signed [COORD_WIDTH-1:0] centroid_y;
	logic                          saturated;

	modport source (output valid, top_left_x, top_left_y, top_right_x, top_right_y,
		bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y,
		centroid_x, centroid_y, saturated, input ready);
	modport sink (input valid, top_left_x, top_left_y, top_right_x, top_right_y,
		bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y,
		centroid_x, centroid_y, saturated, output ready);
endinterface

### rtl/core/qast_cfg_regs.sv
// APB-style configuration registers: move step, scale factors, rotation cos/sin.
// Depends on qast_pkg.
`timescale 1ns / 1ps

module qast_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [qast_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [qast_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [qast_pkg::CFG_DATA_W-1:0] prdata,
	output qast_pkg::cfg_t                  cfg
);
	import qast_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MOVE_STEP:  cfg_q.move_step  <= pwdata[STEP_W-1:0];
				REG_SCALE_UP:   cfg_q.scale_up   <= pwdata[FACTOR_W-1:0];
				REG_SCALE_DOWN: cfg_q.scale_down <= pwdata[FACTOR_W-1:0];
				REG_ROT_COS:    cfg_q.rot_cos    <= $signed(pwdata[FACTOR_W-1:0]);
				REG_ROT_SIN:    cfg_q.rot_sin    <= $signed(pwdata[FACTOR_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MOVE_STEP:  prdata = {{(CFG_DATA_W-STEP_W){1'b0}}, cfg_q.move_step};
			REG_SCALE_UP:   prdata = {{(CFG_DATA_W-FACTOR_W){1'b0}}, cfg_q.scale_up};
			REG_SCALE_DOWN: prdata = {{(CFG_DATA_W-FACTOR_W){1'b0}}, cfg_q.scale_down};
			REG_ROT_COS:    prdata = {{(CFG_DATA_W-FACTOR_W){cfg_q.rot_cos[FACTOR_W-1]}},
				cfg_q.rot_cos};
			REG_ROT_SIN:    prdata = {{(CFG_DATA_W-FACTOR_W){cfg_q.rot_sin[FACTOR_W-1]}},
				cfg_q.rot_sin};
			default:        prdata = '0;
		endcase
	end

endmodule

### rtl/core/qast_lane.sv
// One coordinate lane: new value of one corner coordinate for place, move,
// scale or rotate, with saturation. Depends on qast_pkg.
`timescale 1ns / 1ps

module qast_lane #(
	parameter int COORD_WIDTH = 24,
	parameter bit IS_Y        = 1'b0,
	parameter bit PLACE_NEG   = 1'b0
) (
	input  qast_pkg::act_t                action,
	input  qast_pkg::dir_t                direction,
	input  logic signed [COORD_WIDTH-1:0] place_center,
	input  logic [COORD_WIDTH-2:0]        place_size,
	input  logic signed [COORD_WIDTH-1:0] own,
	input  logic signed [COORD_WIDTH-1:0] other,
	input  logic signed [COORD_WIDTH-1:0] own_cen,
	input  logic signed [COORD_WIDTH-1:0] other_cen,
	input  qast_pkg::cfg_t                cfg,
	output logic signed [COORD_WIDTH-1:0] value,
	output logic                          clamped
);
	import qast_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int PW = W + KW + 2;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FACTOR_FRAC - 1);
	localparam logic signed [PW-1:0] HI   = (PW'(1) <<< (W - 1)) - PW'(1);
	localparam logic signed [PW-1:0] LO   = -HI - PW'(1);

	logic signed [PW-1:0]   center_w, half_w, own_w, own_cen_w, step_w, move_d;
	logic signed [W:0]      d_own, d_oth;
	logic [FACTOR_W-1:0]    factor;
	logic signed [KW-1:0]   k1, k2, sin_w;
	logic                   rotate, s_pos;
	logic signed [W+KW:0]   m1, m2;
	logic signed [PW-1:0]   acc, rnd, raw;

	assign center_w  = PW'(place_center);
	assign half_w    = PW'(place_size >> 1);
	assign own_w     = PW'(own);
	assign own_cen_w = PW'(own_cen);
	assign step_w    = PW'(cfg.move_step);

	always_comb begin
		move_d = '0;
		if (IS_Y) begin
			if (direction == DIR_UP)
				move_d = step_w;
			else if (direction == DIR_DOWN)
				move_d = -step_w;
		end else begin
			if (direction == DIR_RIGHT)
				move_d = step_w;
			else if (direction == DIR_LEFT)
				move_d = -step_w;
		end
	end

	// offsets from the centroid
	assign d_own = (W+1)'(own) - (W+1)'(own_cen);
	assign d_oth = (W+1)'(other) - (W+1)'(other_cen);

	// x' uses -s on the y offset, y' uses +s on the x offset; s = +sin for ccw
	assign rotate = (action == ACT_ROTATE);
	assign factor = (direction == DIR_ENLARGE) ? cfg.scale_up : cfg.scale_down;
	assign sin_w  = KW'(cfg.rot_sin);
	assign s_pos  = ((direction == DIR_CCW) == IS_Y);
	assign k1     = rotate ? KW'(cfg.rot_cos) : $signed(KW'(factor));
	assign k2     = rotate ? (s_pos ? sin_w : -sin_w) : '0;

	assign m1  = d_own * k1;
	assign m2  = d_oth * k2;
	assign acc = PW'(m1) + PW'(m2);
	assign rnd = (acc + HALF) >>> FACTOR_FRAC;

	always_comb begin
		case (action)
			ACT_PLACE: raw = PLACE_NEG ? (center_w - half_w) : (center_w + half_w);
			ACT_MOVE:  raw = own_w + move_d;
			default:   raw = own_cen_w + rnd;
		endcase
	end

	always_comb begin
		clamped = 1'b1;
		if (raw > HI)
			value = HI[W-1:0];
		else if (raw < LO)
			value = LO[W-1:0];
		else begin
			value   = raw[W-1:0];
			clamped = 1'b0;
		end
	end

endmodule

### rtl/core/quad_affine_step_transform_core.sv
// Top level of the quad affine step transform: request register, eight
// coordinate lanes, corner/centroid state that doubles as the result register.
// Depends on qast_pkg, qast_if, qast_cfg_regs, qast_lane.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------------
//   cmd     | in  | valid/ready        | action, direction, center_x/y, box w/h
//   res     | out | valid/ready        | four corners x/y, centroid x/y, saturated
//   apb     | in  | psel/penable/pready| 5 registers at byte address 4*index
//
// Throughput: one request per cycle while res.ready is high. A request passes
// through the request register, then the corner state register, to result valid.
// The rate is set by the corner state loop: each request reads the corners
// and centroid left by the one before, through one lane pass.
// Stalls: while a result waits, one further request is held in the request
// register; cmd.ready drops only when both are full.
// Reset (arst_n low): corners and centroid cleared to zero, registers to
// their defaults, both channels empty.
`timescale 1ns / 1ps

module quad_affine_step_transform_core #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	qast_cmd_if.sink                        cmd,
	qast_res_if.source                      res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [qast_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [qast_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [qast_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);
	import qast_pkg::*;

	localparam int W = COORD_WIDTH;
	// corners in order tl, tr, br, bl; bit set where place subtracts half size
	localparam logic [3:0] PLACE_NEG_X = 4'b1001;
	localparam logic [3:0] PLACE_NEG_Y = 4'b1100;

	cfg_t cfg;

	// request register
	logic                valid_s1;
	act_t                action_s1;
	dir_t                dir_s1;
	logic signed [W-1:0] center_x_s1, center_y_s1;
	logic [W-2:0]        box_w_s1, box_h_s1;

	// corner state, also the result payload
	logic signed [W-1:0] cx_q [4];
	logic signed [W-1:0] cy_q [4];
	logic signed [W-1:0] cen_x_q, cen_y_q;
	logic                sat_q;
	logic                res_valid_q;

	logic signed [W-1:0] nx [4];
	logic signed [W-1:0] ny [4];
	logic [3:0]          sat_x, sat_y;
	logic signed [W+1:0] sum_x, sum_y;
	logic                cmd_acc, adv;

	assign pready = 1'b1;

	qast_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// request moves on when the result slot is empty or being emptied
	assign adv       = valid_s1 & (~res_valid_q | res.ready);
	assign cmd.ready = ~valid_s1 | adv;
	assign cmd_acc   = cmd.valid & cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			action_s1   <= act_t'(cmd.action);
			dir_s1      <= cmd.direction;
			center_x_s1 <= cmd.center_x;
			center_y_s1 <= cmd.center_y;
			box_w_s1    <= cmd.box_width;
			box_h_s1    <= cmd.box_height;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_corner
		qast_lane #(
			.COORD_WIDTH (W),
			.IS_Y        (1'b0),
			.PLACE_NEG   (PLACE_NEG_X[i])
		) u_lane_x (
			.action       (action_s1),
			.direction    (dir_s1),
			.place_center (center_x_s1),
			.place_size   (box_w_s1),
			.own          (cx_q[i]),
			.other        (cy_q[i]),
			.own_cen      (cen_x_q),
			.other_cen    (cen_y_q),
			.cfg          (cfg),
			.value        (nx[i]),
			.clamped      (sat_x[i])
		);

		qast_lane #(
			.COORD_WIDTH (W),
			.IS_Y        (1'b1),
			.PLACE_NEG   (PLACE_NEG_Y[i])
		) u_lane_y (
			.action       (action_s1),
			.direction    (dir_s1),
			.place_center (center_y_s1),
			.place_size   (box_h_s1),
			.own          (cy_q[i]),
			.other        (cx_q[i]),
			.own_cen      (cen_y_q),
			.other_cen    (cen_x_q),
			.cfg          (cfg),
			.value        (ny[i]),
			.clamped      (sat_y[i])
		);
	end

	// centroid of the new corners, floor of sum/4
	assign sum_x = (W+2)'(nx[0]) + (W+2)'(nx[1]) + (W+2)'(nx[2]) + (W+2)'(nx[3]);
	assign sum_y = (W+2)'(ny[0]) + (W+2)'(ny[1]) + (W+2)'(ny[2]) + (W+2)'(ny[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				cx_q[i] <= '0;
				cy_q[i] <= '0;
			end
			cen_x_q     <= '0;
			cen_y_q     <= '0;
			sat_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				for (int i = 0; i < 4; i++) begin
					cx_q[i] <= nx[i];
					cy_q[i] <= ny[i];
				end
				cen_x_q <= sum_x[W+1:2];
				cen_y_q <= sum_y[W+1:2];
				sat_q   <= |{sat_x, sat_y};
			end
			if (adv)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.top_left_x     = cx_q[0];
	assign res.top_left_y     = cy_q[0];
	assign res.top_right_x    = cx_q[1];
	assign res.top_right_y    = cy_q[1];
	assign res.bottom_right_x = cx_q[2];
	assign res.bottom_right_y = cy_q[2];
	assign res.bottom_left_x  = cx_q[3];
	assign res.bottom_left_y  = cy_q[3];
	assign res.centroid_x     = cen_x_q;
	assign res.centroid_y     = cen_y_q;
	assign res.saturated      = sat_q;

endmodule

### rtl/core/qast_checker.sv
// Port-level checks for the transform core, attached by bind.
// Depends on quad_affine_step_transform_core and the channel interfaces.
`timescale 1ns / 1ps

module qast_checker #(
	parameter int COORD_WIDTH = 24
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic signed [COORD_WIDTH-1:0] tl_x,
	input logic signed [COORD_WIDTH-1:0] tl_y,
	input logic signed [COORD_WIDTH-1:0] tr_x,
	input logic signed [COORD_WIDTH-1:0] tr_y,
	input logic signed [COORD_WIDTH-1:0] br_x,
	input logic signed [COORD_WIDTH-1:0] br_y,
	input logic signed [COORD_WIDTH-1:0] bl_x,
	input logic signed [COORD_WIDTH-1:0] bl_y,
	input logic signed [COORD_WIDTH-1:0] cen_x,
	input logic signed [COORD_WIDTH-1:0] cen_y,
	input logic                          saturated
);
	localparam int W = COORD_WIDTH;

	logic signed [W+1:0] sum_x, sum_y;

	assign sum_x = (W+2)'(tl_x) + (W+2)'(tr_x) + (W+2)'(br_x) + (W+2)'(bl_x);
	assign sum_y = (W+2)'(tl_y) + (W+2)'(tr_y) + (W+2)'(br_y) + (W+2)'(bl_y);

	// only a backed-up result may hold off requests
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> (res_valid && !res_ready))
		else $error("request stalled without a pending result");

	// shown centroid is the floor mean of the shown corners
	a_centroid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (cen_x == sum_x[W+1:2] && cen_y == sum_y[W+1:2]))
		else $error("centroid does not match corners");

	// held result keeps its corner and saturated payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(tl_x) && $stable(tl_y)
			&& $stable(tr_x) && $stable(tr_y) && $stable(br_x) && $stable(br_y)
			&& $stable(bl_x) && $stable(bl_y) && $stable(saturated)))
		else $error("stalled result changed");

	// a request accepted into an empty core shows up through the request and corner state registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready && !res_valid && res_ready) |=> ##1 res_valid)
		else $error("result missing after request");

endmodule

bind quad_affine_step_transform_core qast_checker #(.COORD_WIDTH(COORD_WIDTH)) u_qast_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.tl_x      (res.top_left_x),
	.tl_y      (res.top_left_y),
	.tr_x      (res.top_right_x),
	.tr_y      (res.top_right_y),
	.br_x      (res.bottom_right_x),
	.br_y      (res.bottom_right_y),
	.bl_x      (res.bottom_left_x),
	.bl_y      (res.bottom_left_y),
	.cen_x     (res.centroid_x),
	.cen_y     (res.centroid_y),
	.saturated (res.saturated)
);
